### rtl/rwks_pkg.sv
// shared types, constants and float helpers for the key scorer
`default_nettype none

package rwks_pkg;

  localparam int MAX_HEADS  = 64;
  localparam int EMBED_SIZE = 128;
  localparam int HEAD_W     = $clog2(MAX_HEADS);
  localparam int ELEM_W     = $clog2(EMBED_SIZE);
  localparam int HC_W       = 7;
  localparam int FMT_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int MUL_LAT    = 3;
  localparam int ADD_LAT    = 2;
  localparam int WAIT_W     = 3;
  localparam logic [WAIT_W-1:0] MAC_WAIT = WAIT_W'(MUL_LAT + ADD_LAT);
  localparam logic [WAIT_W-1:0] SCR_WAIT = WAIT_W'(MUL_LAT);

  localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
  localparam logic [31:0] FP_ZERO      = 32'h0000_0000;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_WEIGHT = 2'd1,
    OP_KEY    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [FMT_W-1:0] {
    FMT_F32  = 3'd0,
    FMT_F16  = 3'd1,
    FMT_BF16 = 3'd2,
    FMT_Q8_0 = 3'd3,
    FMT_Q4_0 = 3'd4,
    FMT_Q4_1 = 3'd5,
    FMT_Q5_0 = 3'd6,
    FMT_Q5_1 = 3'd7
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_FORMAT = 1'b0,
    REG_HEAD_COUNT = 1'b1
  } reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DMUL,
    ST_DMULW,
    ST_DADD,
    ST_DADDW,
    ST_RD,
    ST_MAC,
    ST_MACW,
    ST_SCR,
    ST_SCRW,
    ST_CHAIN,
    ST_CHAINW,
    ST_MASK,
    ST_MASKW
  } state_t;

  typedef struct packed {
    logic              wr_q;
    logic              wr_w;
    logic [HEAD_W-1:0] head;
    logic [ELEM_W-1:0] elem;
    logic [31:0]       data;
    logic              rd;
    logic              mac;
    logic              score;
    logic              clr;
    logic [HC_W-1:0]   head_count;
  } cell_ctl_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic [4:0] lz24(input logic [23:0] x);
    logic [4:0] pos;
    pos = '0;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) pos = 5'(i);
    end
    return (x == 24'd0) ? 5'd24 : 5'd23 - pos;
  endfunction

  function automatic logic [4:0] lz27(input logic [26:0] x);
    logic [4:0] pos;
    pos = '0;
    for (int i = 0; i < 27; i++) begin
      if (x[i]) pos = 5'(i);
    end
    return (x == 27'd0) ? 5'd27 : 5'd26 - pos;
  endfunction

  function automatic logic [31:0] half_to_float(input logic [15:0] h);
    logic [3:0]  p;
    logic [23:0] t;
    logic [31:0] r;
    p = '0;
    for (int i = 0; i < 10; i++) begin
      if (h[i]) p = 4'(i);
    end
    t = 24'(h[9:0]) << (5'd23 - 5'(p));
    if (h[14:10] == 5'd0) begin
      if (h[9:0] == 10'd0) r = {h[15], 31'd0};
      else r = {h[15], 8'(p) + 8'd103, t[22:0]};
    end else if (h[14:10] == 5'h1F) begin
      r = {h[15], 8'hFF, h[9:0], 13'd0};
    end else begin
      r = {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] int_to_float(input logic signed [8:0] v);
    logic [8:0]  mag;
    logic [3:0]  p;
    logic [31:0] t;
    mag = v[8] ? 9'(-v) : 9'(v);
    p = '0;
    for (int i = 0; i < 9; i++) begin
      if (mag[i]) p = 4'(i);
    end
    t = 32'(mag) << (5'd23 - 5'(p));
    return (mag == 9'd0) ? FP_ZERO : {v[8], 8'd127 + 8'(p), t[22:0]};
  endfunction

  function automatic logic [31:0] relu(input logic [31:0] x);
    return (!x[31] && (x[30:0] != 31'd0) && !is_nan(x)) ? x : FP_ZERO;
  endfunction

endpackage

`default_nettype wire

### rtl/rwks_fmul.sv
// three stage binary32 multiplier, round to nearest even
`default_nettype none

module rwks_fmul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        vld,
  output logic [31:0] p
);

  logic              spec, sgn;
  logic [31:0]       specv;
  logic [7:0]        ea_eff, eb_eff;
  logic [23:0]       ma, mb;
  logic [4:0]        lza, lzb;
  logic signed [9:0] ea_n, eb_n;

  logic              vld0_r, spec0_r, sgn0_r;
  logic [31:0]       specv0_r;
  logic signed [9:0] ea0_r, eb0_r;
  logic [23:0]       ma0_r, mb0_r;

  logic               vld1_r, spec1_r, sgn1_r;
  logic [31:0]        specv1_r;
  logic signed [11:0] e1_r;
  logic [47:0]        prod1_r;

  logic [47:0]        pn, dd;
  logic signed [11:0] ee, tmp;
  logic [5:0]         sh;
  logic               lost, rnd;
  logic [7:0]         ef;
  logic [30:0]        s31;
  logic [31:0]        res;

  logic        vld_r;
  logic [31:0] p_r;

  always_comb begin
    sgn  = a[31] ^ b[31];
    spec = rwks_pkg::is_nan(a) || rwks_pkg::is_nan(b) || rwks_pkg::is_inf(a) ||
           rwks_pkg::is_inf(b) || (a[30:0] == 31'd0) || (b[30:0] == 31'd0);
    if (rwks_pkg::is_nan(a)) begin
      specv = a | rwks_pkg::QUIET_BIT;
    end else if (rwks_pkg::is_nan(b)) begin
      specv = b | rwks_pkg::QUIET_BIT;
    end else if ((rwks_pkg::is_inf(a) && (b[30:0] == 31'd0)) ||
                 (rwks_pkg::is_inf(b) && (a[30:0] == 31'd0))) begin
      specv = rwks_pkg::QNAN_DEFAULT;
    end else if (rwks_pkg::is_inf(a) || rwks_pkg::is_inf(b)) begin
      specv = {sgn, 8'hFF, 23'd0};
    end else begin
      specv = {sgn, 31'd0};
    end
    ea_eff = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb_eff = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    lza    = rwks_pkg::lz24(ma);
    lzb    = rwks_pkg::lz24(mb);
    ea_n   = $signed({2'b00, ea_eff}) - $signed({5'd0, lza});
    eb_n   = $signed({2'b00, eb_eff}) - $signed({5'd0, lzb});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      vld0_r <= go;
      vld1_r <= vld0_r;
      vld_r  <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    spec0_r  <= spec;
    specv0_r <= specv;
    sgn0_r   <= sgn;
    ea0_r    <= ea_n;
    eb0_r    <= eb_n;
    ma0_r    <= ma << lza;
    mb0_r    <= mb << lzb;
    spec1_r  <= spec0_r;
    specv1_r <= specv0_r;
    sgn1_r   <= sgn0_r;
    e1_r     <= $signed({{2{ea0_r[9]}}, ea0_r}) + $signed({{2{eb0_r[9]}}, eb0_r}) - 12'sd127;
    prod1_r  <= ma0_r * mb0_r;
    p_r      <= spec1_r ? specv1_r : res;
  end

  always_comb begin
    if (prod1_r[47]) begin
      pn = prod1_r;
      ee = e1_r + 12'sd1;
    end else begin
      pn = prod1_r << 1;
      ee = e1_r;
    end
    tmp  = 12'sd1 - ee;
    sh   = (ee >= 12'sd1) ? 6'd0 : ((tmp > 12'sd63) ? 6'd63 : tmp[5:0]);
    dd   = pn >> sh;
    lost = |(pn & ~({48{1'b1}} << sh));
    rnd  = dd[23] & (lost | (|dd[22:0]) | dd[24]);
    ef   = (ee >= 12'sd1) ? ee[7:0] : 8'd0;
    s31  = {ef, dd[46:24]} + 31'(rnd);
    res  = (ee >= 12'sd255) ? {sgn1_r, 8'hFF, 23'd0} : {sgn1_r, s31};
  end

  assign vld = vld_r;
  assign p   = p_r;

endmodule

`default_nettype wire

### rtl/rwks_fadd.sv
// two stage binary32 adder, round to nearest even
`default_nettype none

module rwks_fadd (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        vld,
  output logic [31:0] s
);

  logic        spec, a_big, sub, stk;
  logic [31:0] specv, big, sml;
  logic [7:0]  eb, es, d;
  logic [4:0]  dc;
  logic [26:0] mbig, msml, al;
  logic [27:0] sum;

  logic        vld0_r, spec0_r, sgn0_r;
  logic [31:0] specv0_r;
  logic [8:0]  e0_r;
  logic [27:0] sum0_r;

  logic [4:0]  lz, sh;
  logic [8:0]  lim, ee;
  logic [26:0] nn;
  logic        rnd;
  logic [7:0]  ef;
  logic [30:0] s31;
  logic [31:0] res;

  logic        vld_r;
  logic [31:0] s_r;

  always_comb begin
    spec = rwks_pkg::is_nan(a) || rwks_pkg::is_nan(b) || rwks_pkg::is_inf(a) ||
           rwks_pkg::is_inf(b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
    if (rwks_pkg::is_nan(a)) begin
      specv = a | rwks_pkg::QUIET_BIT;
    end else if (rwks_pkg::is_nan(b)) begin
      specv = b | rwks_pkg::QUIET_BIT;
    end else if (rwks_pkg::is_inf(a) && rwks_pkg::is_inf(b) && (a[31] != b[31])) begin
      specv = rwks_pkg::QNAN_DEFAULT;
    end else if (rwks_pkg::is_inf(a)) begin
      specv = a;
    end else if (rwks_pkg::is_inf(b)) begin
      specv = b;
    end else begin
      specv = {a[31] & b[31], 31'd0};
    end
    a_big = a[30:0] >= b[30:0];
    big   = a_big ? a : b;
    sml   = a_big ? b : a;
    sub   = a[31] ^ b[31];
    eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mbig  = {big[30:23] != 8'd0, big[22:0], 3'd0};
    msml  = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
    d     = eb - es;
    dc    = (d > 8'd27) ? 5'd27 : d[4:0];
    stk   = |(msml & ~({27{1'b1}} << dc));
    al    = (msml >> dc) | {26'd0, stk};
    sum   = sub ? ({1'b0, mbig} - {1'b0, al}) : ({1'b0, mbig} + {1'b0, al});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      vld0_r <= go;
      vld_r  <= vld0_r;
    end
  end

  always_ff @(posedge clk) begin
    spec0_r  <= spec;
    specv0_r <= specv;
    sgn0_r   <= big[31];
    e0_r     <= {1'b0, eb};
    sum0_r   <= sum;
    s_r      <= spec0_r ? specv0_r : res;
  end

  always_comb begin
    lz  = rwks_pkg::lz27(sum0_r[26:0]);
    lim = e0_r - 9'd1;
    sh  = (9'(lz) <= lim) ? lz : lim[4:0];
    if (sum0_r[27]) begin
      nn = {sum0_r[27:2], sum0_r[1] | sum0_r[0]};
      ee = e0_r + 9'd1;
    end else begin
      nn = sum0_r[26:0] << sh;
      ee = e0_r - 9'(sh);
    end
    rnd = nn[2] & (nn[1] | nn[0] | nn[3]);
    ef  = nn[26] ? ee[7:0] : 8'd0;
    s31 = {ef, nn[25:3]} + 31'(rnd);
    if (sum0_r == 28'd0) begin
      res = rwks_pkg::FP_ZERO;
    end else if (ee >= 9'd255) begin
      res = {sgn0_r, 8'hFF, 23'd0};
    end else begin
      res = {sgn0_r, s31};
    end
  end

  assign vld = vld_r;
  assign s   = s_r;

endmodule

`default_nettype wire

### rtl/rwks_cell.sv
// one head cell: query memory, weight, accumulator, chain adder stage
`default_nettype none

module rwks_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rwks_pkg::HEAD_W-1:0] cell_idx,
  input  rwks_pkg::cell_ctl_t         ctl,
  input  logic [31:0]                 sum_in,
  input  logic                        sum_in_vld,
  output logic [31:0]                 sum_out,
  output logic                        sum_out_vld
);

  logic [31:0] qmem [rwks_pkg::EMBED_SIZE];
  logic [31:0] q_rd_r, w_r, acc_r, t_r, pass_r;
  logic        pass_vld_r, mul_score_r, add_chain_r;
  logic        active, sel;
  logic        mul_go, mul_vld, add_go, add_vld;
  logic [31:0] mul_a, mul_b, mul_p, add_a, add_b, add_s;

  assign active = rwks_pkg::HC_W'(cell_idx) < ctl.head_count;
  assign sel    = cell_idx == ctl.head;

  always_ff @(posedge clk) begin
    if (ctl.wr_q && sel) qmem[ctl.elem] <= ctl.data;
    if (ctl.rd) q_rd_r <= qmem[ctl.elem];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_w && sel) w_r <= ctl.data;
    if (mul_vld && mul_score_r) t_r <= mul_p;
    pass_r <= sum_in;
  end

  assign mul_go = (ctl.mac || ctl.score) && active;
  assign mul_a  = ctl.score ? rwks_pkg::relu(acc_r) : q_rd_r;
  assign mul_b  = ctl.score ? w_r : ctl.data;
  assign add_go = (mul_vld && !mul_score_r) || (sum_in_vld && active);
  assign add_a  = sum_in_vld ? sum_in : acc_r;
  assign add_b  = sum_in_vld ? t_r : mul_p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= rwks_pkg::FP_ZERO;
      mul_score_r <= 1'b0;
      add_chain_r <= 1'b0;
      pass_vld_r  <= 1'b0;
    end else begin
      pass_vld_r <= sum_in_vld && !active;
      priority if (ctl.score && active) mul_score_r <= 1'b1;
      else if (mul_vld) mul_score_r <= 1'b0;
      priority if (sum_in_vld && active) add_chain_r <= 1'b1;
      else if (add_vld) add_chain_r <= 1'b0;
      priority if (ctl.clr) acc_r <= rwks_pkg::FP_ZERO;
      else if (add_vld && !add_chain_r) acc_r <= add_s;
    end
  end

  rwks_fmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .vld   (mul_vld),
    .p     (mul_p)
  );

  rwks_fadd u_add (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (add_go),
    .a     (add_a),
    .b     (add_b),
    .vld   (add_vld),
    .s     (add_s)
  );

  assign sum_out     = active ? add_s : pass_r;
  assign sum_out_vld = active ? (add_vld && add_chain_r) : pass_vld_r;

endmodule

`default_nettype wire

### rtl/relu_weighted_key_scorer_top.sv
// top level of the relu weighted key scorer: decoder, sequencer, row of head cells
//
// Use: write key_format and head_count on the cfg_ port (cfg_ready is always
// high) while idle. Push items with start while busy is low. Query and weight
// loads leave busy low. A key element raises busy: f32, f16 and bf16 keys go
// straight to the cells, q4_0/q5_0/q8_0 add a scale multiply and q4_1/q5_1 a
// scale multiply and offset add in the shared decode units. On the last
// element the cells form weight*relu(acc) and the partial sum then walks
// down the row of 64 cells, through the adder of each active cell and a
// pass register in each inactive one, then the mask is added. The score
// word is on out_score_bits with out_valid high for one cycle; the receiver
// must take it then. Reset clears the accumulators, the sequencer and the
// config registers (key_format 1, head_count 64); query and weight storage
// hold garbage until loaded.
`default_nettype none

module relu_weighted_key_scorer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [5:0]  in_head_index,
  input  logic [6:0]  in_element_index,
  input  logic [31:0] in_value_bits,
  input  logic [15:0] in_key_scale,
  input  logic [15:0] in_key_min,
  input  logic [15:0] in_mask_bits,
  input  logic        in_last_element,
  output logic        out_valid,
  output logic [31:0] out_score_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [rwks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rwks_pkg::CFG_DATA_W-1:0] cfg_data
);

  rwks_pkg::state_t state_r, state_nxt;
  logic [rwks_pkg::WAIT_W-1:0] cnt_r, cnt_nxt;

  logic [rwks_pkg::FMT_W-1:0] key_format_r;
  logic [rwks_pkg::HC_W-1:0]  head_count_r;

  logic [31:0] val_r, key_r, sum_r, out_score_r;
  logic [15:0] scale_r, min_r, mask_r;
  logic        last_r, elem_ok_r, out_valid_r;
  logic [rwks_pkg::ELEM_W-1:0] elem_r;

  logic        accept, is_key, head_ok, elem_ok_in;
  logic [31:0] key_direct;
  logic signed [8:0] code;
  rwks_pkg::fmt_t fmt;

  logic        dmul_go, dmul_vld, dadd_go, dadd_vld;
  logic [31:0] dmul_a, dmul_b, dmul_p, dadd_a, dadd_b, dadd_s;

  rwks_pkg::cell_ctl_t ctl;
  logic [31:0] chain_sum [rwks_pkg::MAX_HEADS+1];
  logic [rwks_pkg::MAX_HEADS:0] chain_vld;

  assign fmt        = rwks_pkg::fmt_t'(key_format_r);
  assign busy       = state_r != rwks_pkg::ST_IDLE;
  assign accept     = start && !busy;
  assign is_key     = rwks_pkg::op_t'(in_operation) == rwks_pkg::OP_KEY;
  assign head_ok    = 32'(in_head_index) < rwks_pkg::MAX_HEADS;
  assign elem_ok_in = 32'(in_element_index) < rwks_pkg::EMBED_SIZE;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_format_r <= rwks_pkg::FMT_F16;
      head_count_r <= rwks_pkg::HC_W'(rwks_pkg::MAX_HEADS);
    end else if (cfg_valid) begin
      unique case (rwks_pkg::reg_t'(cfg_index))
        rwks_pkg::REG_KEY_FORMAT: key_format_r <= cfg_data[rwks_pkg::FMT_W-1:0];
        rwks_pkg::REG_HEAD_COUNT: head_count_r <= cfg_data;
      endcase
    end
  end

  always_comb begin
    unique case (fmt)
      rwks_pkg::FMT_F16:  key_direct = rwks_pkg::half_to_float(in_value_bits[15:0]);
      rwks_pkg::FMT_BF16: key_direct = {in_value_bits[15:0], 16'd0};
      default:            key_direct = in_value_bits;
    endcase
    unique case (fmt)
      rwks_pkg::FMT_Q8_0: code = $signed({val_r[7], val_r[7:0]});
      rwks_pkg::FMT_Q4_0: code = $signed({5'd0, val_r[3:0]}) - 9'sd8;
      rwks_pkg::FMT_Q4_1: code = $signed({5'd0, val_r[3:0]});
      rwks_pkg::FMT_Q5_0: code = $signed({4'd0, val_r[4:0]}) - 9'sd16;
      rwks_pkg::FMT_Q5_1: code = $signed({4'd0, val_r[4:0]});
      default:            code = 9'sd0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rwks_pkg::ST_IDLE: begin
        if (accept && is_key) begin
          state_nxt = (key_format_r >= rwks_pkg::FMT_Q8_0) ? rwks_pkg::ST_DMUL
                                                           : rwks_pkg::ST_RD;
        end
      end
      rwks_pkg::ST_DMUL: state_nxt = rwks_pkg::ST_DMULW;
      rwks_pkg::ST_DMULW: begin
        if (dmul_vld) begin
          state_nxt = (fmt == rwks_pkg::FMT_Q4_1 || fmt == rwks_pkg::FMT_Q5_1)
                      ? rwks_pkg::ST_DADD : rwks_pkg::ST_RD;
        end
      end
      rwks_pkg::ST_DADD: state_nxt = rwks_pkg::ST_DADDW;
      rwks_pkg::ST_DADDW: begin
        if (dadd_vld) state_nxt = rwks_pkg::ST_RD;
      end
      rwks_pkg::ST_RD:  state_nxt = rwks_pkg::ST_MAC;
      rwks_pkg::ST_MAC: state_nxt = rwks_pkg::ST_MACW;
      rwks_pkg::ST_MACW: begin
        if (cnt_r == rwks_pkg::MAC_WAIT) begin
          state_nxt = last_r ? rwks_pkg::ST_SCR : rwks_pkg::ST_IDLE;
        end
      end
      rwks_pkg::ST_SCR: state_nxt = rwks_pkg::ST_SCRW;
      rwks_pkg::ST_SCRW: begin
        if (cnt_r == rwks_pkg::SCR_WAIT) state_nxt = rwks_pkg::ST_CHAIN;
      end
      rwks_pkg::ST_CHAIN: state_nxt = rwks_pkg::ST_CHAINW;
      rwks_pkg::ST_CHAINW: begin
        if (chain_vld[rwks_pkg::MAX_HEADS]) state_nxt = rwks_pkg::ST_MASK;
      end
      rwks_pkg::ST_MASK: state_nxt = rwks_pkg::ST_MASKW;
      rwks_pkg::ST_MASKW: begin
        if (dadd_vld) state_nxt = rwks_pkg::ST_IDLE;
      end
      default: state_nxt = rwks_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctl.wr_q       = accept && (rwks_pkg::op_t'(in_operation) == rwks_pkg::OP_QUERY) &&
                     head_ok && elem_ok_in;
    ctl.wr_w       = accept && (rwks_pkg::op_t'(in_operation) == rwks_pkg::OP_WEIGHT) &&
                     head_ok;
    ctl.head       = rwks_pkg::HEAD_W'(in_head_index);
    ctl.elem       = busy ? elem_r : rwks_pkg::ELEM_W'(in_element_index);
    ctl.data       = busy ? key_r : in_value_bits;
    ctl.rd         = state_r == rwks_pkg::ST_RD;
    ctl.mac        = (state_r == rwks_pkg::ST_MAC) && elem_ok_r;
    ctl.score      = state_r == rwks_pkg::ST_SCR;
    ctl.clr        = (state_r == rwks_pkg::ST_MASKW) && dadd_vld;
    ctl.head_count = head_count_r;
    dmul_go        = state_r == rwks_pkg::ST_DMUL;
    dmul_a         = rwks_pkg::half_to_float(scale_r);
    dmul_b         = rwks_pkg::int_to_float(code);
    dadd_go        = (state_r == rwks_pkg::ST_DADD) || (state_r == rwks_pkg::ST_MASK);
    dadd_a         = (state_r == rwks_pkg::ST_MASK) ? sum_r : key_r;
    dadd_b         = rwks_pkg::half_to_float((state_r == rwks_pkg::ST_MASK) ? mask_r : min_r);
  end

  always_comb begin
    cnt_nxt = (state_r == rwks_pkg::ST_MACW || state_r == rwks_pkg::ST_SCRW)
              ? cnt_r + 1'b1 : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rwks_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_r == rwks_pkg::ST_MASKW) && dadd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_key) begin
      val_r     <= in_value_bits;
      scale_r   <= in_key_scale;
      min_r     <= in_key_min;
      mask_r    <= in_mask_bits;
      last_r    <= in_last_element;
      elem_r    <= rwks_pkg::ELEM_W'(in_element_index);
      elem_ok_r <= elem_ok_in;
      key_r     <= key_direct;
    end else if (state_r == rwks_pkg::ST_DMULW && dmul_vld) begin
      key_r <= dmul_p;
    end else if (state_r == rwks_pkg::ST_DADDW && dadd_vld) begin
      key_r <= dadd_s;
    end
    if (state_r == rwks_pkg::ST_CHAINW && chain_vld[rwks_pkg::MAX_HEADS]) begin
      sum_r <= chain_sum[rwks_pkg::MAX_HEADS];
    end
    if (state_r == rwks_pkg::ST_MASKW && dadd_vld) out_score_r <= dadd_s;
  end

  rwks_fmul u_dmul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (dmul_go),
    .a     (dmul_a),
    .b     (dmul_b),
    .vld   (dmul_vld),
    .p     (dmul_p)
  );

  rwks_fadd u_dadd (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (dadd_go),
    .a     (dadd_a),
    .b     (dadd_b),
    .vld   (dadd_vld),
    .s     (dadd_s)
  );

  assign chain_sum[0] = rwks_pkg::FP_ZERO;
  assign chain_vld[0] = state_r == rwks_pkg::ST_CHAIN;

  for (genvar h = 0; h < rwks_pkg::MAX_HEADS; h++) begin : g_cell
    rwks_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (rwks_pkg::HEAD_W'(h)),
      .ctl         (ctl),
      .sum_in      (chain_sum[h]),
      .sum_in_vld  (chain_vld[h]),
      .sum_out     (chain_sum[h+1]),
      .sum_out_vld (chain_vld[h+1])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_score_bits = out_score_r;

endmodule

`default_nettype wire

### rtl/rwks_checker.sv
// port level checks for the key scorer and their bind
`default_nettype none

module rwks_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_operation,
  input logic       out_valid
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("score strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("score strobe while busy");

  a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == 2'd2) |=> busy)
    else $error("key word did not start work");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation != 2'd2) |=> (!busy && !out_valid))
    else $error("load word left block busy or gave a score");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("reset did not idle the block");

endmodule

bind relu_weighted_key_scorer_top rwks_checker u_rwks_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_operation (in_operation),
  .out_valid    (out_valid)
);

`default_nettype wire

### test/testbench.sv
// self-checking testbench for the relu weighted key scorer with a bit-exact fp32 score predictor
`timescale 1ns / 100ps

module testbench;
  import rwks_pkg::*;

  localparam int QUIET_CYCLES = 250;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [31:0] NAN_WORD = 32'h7FC0_0000;

  typedef struct packed {
    logic        is_cfg;
    reg_t        idx;
    logic [6:0]  cdata;
    op_t         op;
    logic [5:0]  head;
    logic [6:0]  elem;
    logic [31:0] val;
    logic [15:0] scale;
    logic [15:0] minv;
    logic [15:0] mask;
    logic        last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = '0;
  logic [5:0]  in_head_index = '0;
  logic [6:0]  in_element_index = '0;
  logic [31:0] in_value_bits = '0;
  logic [15:0] in_key_scale = '0;
  logic [15:0] in_key_min = '0;
  logic [15:0] in_mask_bits = '0;
  logic        in_last_element = 1'b0;
  logic        out_valid;
  logic [31:0] out_score_bits;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  relu_weighted_key_scorer_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_head_index(in_head_index),
    .in_element_index(in_element_index), .in_value_bits(in_value_bits),
    .in_key_scale(in_key_scale), .in_key_min(in_key_min),
    .in_mask_bits(in_mask_bits), .in_last_element(in_last_element),
    .out_valid(out_valid), .out_score_bits(out_score_bits),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  word_t       pending_words[$];
  logic [31:0] expected_scores[$];
  word_t       cur_word;
  int          gap_left = 0;
  int          quiet = 0;
  int          cycles = 0;
  int          errors = 0;
  int          words_sent = 0;
  int          scores_checked = 0;
  bit          no_gaps = 0;

  logic [31:0] query_mem [MAX_HEADS][EMBED_SIZE];
  logic [31:0] weight_mem [MAX_HEADS];
  logic [31:0] acc [MAX_HEADS];
  fmt_t        key_fmt;
  logic [6:0]  heads_reg;

  int          known_elems[$];
  bit          elem_known [EMBED_SIZE];

  // ---------------- fp32 arithmetic, round to nearest even ----------------

  function automatic logic fp_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 0);
  endfunction

  function automatic logic fp_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 0);
  endfunction

  function automatic logic [23:0] fp_mant(input logic [31:0] x);
    return {|x[30:23], x[22:0]};
  endfunction

  function automatic int fp_exp(input logic [31:0] x);
    return ((x[30:23] == 0) ? 1 : int'(x[30:23])) - 150;
  endfunction

  // value = m * 2^e
  function automatic logic [31:0] fp_round(input logic s, input int e, input logic [63:0] m);
    int p, sh, bexp;
    logic [127:0] w, keep, rem, half;
    if (m == 0) return {s, 31'd0};
    p = 0;
    for (int i = 0; i < 64; i++) if (m[i]) p = i;
    sh = p - 23;
    if (-149 - e > sh) sh = -149 - e;
    w = 128'(m);
    if (sh > 0) begin
      if (sh > 100) sh = 100;
      keep = w >> sh;
      rem = w - (keep << sh);
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 1;
    end else begin
      keep = w << (-sh);
    end
    if (keep[24]) begin
      keep = keep >> 1;
      sh++;
    end
    if (keep[23]) begin
      bexp = sh + e + 150;
      if (bexp >= 255) return {s, 8'hFF, 23'd0};
      return {s, 8'(bexp), keep[22:0]};
    end
    return {s, 8'd0, keep[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (fp_nan(a) || fp_nan(b)) return NAN_WORD;
    if (fp_inf(a) || fp_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return NAN_WORD;
      return {s, 8'hFF, 23'd0};
    end
    return fp_round(s, fp_exp(a) + fp_exp(b), 64'(fp_mant(a)) * 64'(fp_mant(b)));
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x, y;
    logic [63:0] ma, mb, t;
    int d;
    if (fp_nan(a) || fp_nan(b)) return NAN_WORD;
    if (fp_inf(a) && fp_inf(b)) return (a[31] == b[31]) ? a : NAN_WORD;
    if (fp_inf(a)) return a;
    if (fp_inf(b)) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
    x = a;
    y = b;
    if (fp_exp(b) > fp_exp(a)) begin
      x = b;
      y = a;
    end
    d = fp_exp(x) - fp_exp(y);
    ma = 64'(fp_mant(x)) << 38;
    mb = 64'(fp_mant(y)) << 38;
    if (d >= 62) begin
      mb = (mb != 0) ? 64'd1 : 64'd0;
    end else begin
      t = mb >> d;
      if ((t << d) != mb) t[0] = 1'b1;
      mb = t;
    end
    if (x[31] == y[31]) return fp_round(x[31], fp_exp(x) - 38, ma + mb);
    if (ma == mb) return 32'd0;
    if (ma > mb) return fp_round(x[31], fp_exp(x) - 38, ma - mb);
    return fp_round(y[31], fp_exp(x) - 38, mb - ma);
  endfunction

  function automatic logic [31:0] half_bits_to_fp(input logic [15:0] h);
    if (h[14:10] == 0) return fp_round(h[15], -24, 64'(h[9:0]));
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
    return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
  endfunction

  function automatic logic [31:0] int_to_fp(input int v);
    logic [63:0] mag;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    return fp_round(v < 0, 0, mag);
  endfunction

  function automatic logic [31:0] decode_key_value(input word_t w);
    logic [31:0] d, m;
    d = half_bits_to_fp(w.scale);
    m = half_bits_to_fp(w.minv);
    case (key_fmt)
      FMT_F32:  return w.val;
      FMT_F16:  return half_bits_to_fp(w.val[15:0]);
      FMT_BF16: return {w.val[15:0], 16'd0};
      FMT_Q8_0: return fp_mul(int_to_fp(int'($signed(w.val[7:0]))), d);
      FMT_Q4_0: return fp_mul(d, int_to_fp(int'(w.val[3:0]) - 8));
      FMT_Q4_1: return fp_add(fp_mul(d, int_to_fp(int'(w.val[3:0]))), m);
      FMT_Q5_0: return fp_mul(d, int_to_fp(int'(w.val[4:0]) - 16));
      default:  return fp_add(fp_mul(d, int_to_fp(int'(w.val[4:0]))), m);
    endcase
  endfunction

  task automatic score_predict(input word_t w);
    logic [31:0] key, sum, r;
    int n;
    n = (heads_reg < MAX_HEADS) ? int'(heads_reg) : MAX_HEADS;
    case (w.op)
      OP_QUERY:  query_mem[w.head][w.elem] = w.val;
      OP_WEIGHT: weight_mem[w.head] = w.val;
      OP_KEY: begin
        key = decode_key_value(w);
        for (int h = 0; h < n; h++) acc[h] = fp_add(acc[h], fp_mul(query_mem[h][w.elem], key));
        if (w.last) begin
          sum = 32'd0;
          for (int h = 0; h < n; h++) begin
            r = (!acc[h][31] && acc[h][30:0] != 0 && !fp_nan(acc[h])) ? acc[h] : 32'd0;
            sum = fp_add(sum, fp_mul(r, weight_mem[h]));
          end
          expected_scores.push_back(fp_add(sum, half_bits_to_fp(w.mask)));
          for (int h = 0; h < MAX_HEADS; h++) acc[h] = 32'd0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got);
    $display("mismatch at cycle %0d: %s, expected %h got %h", cycles, what, exp_v, got);
    errors++;
  endtask

  // ---------------- driver ----------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    word_t nxt;
    logic  held;
    cycles <= cycles + 1;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      key_fmt = FMT_F16;
      heads_reg = 7'd64;
      for (int h = 0; h < MAX_HEADS; h++) acc[h] = 32'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_KEY_FORMAT) key_fmt = fmt_t'(cfg_data[2:0]);
        else heads_reg = cfg_data;
      end
      if (start && !busy) begin
        score_predict(cur_word);
        words_sent++;
      end
      if (busy || start || cfg_valid || expected_scores.size() != 0) quiet <= 0;
      else quiet <= quiet + 1;
      held = (start && busy) || (cfg_valid && !cfg_ready);
      if (!held) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
          cfg_valid <= 1'b0;
        end else if (pending_words.size() == 0) begin
          start <= 1'b0;
          cfg_valid <= 1'b0;
        end else if (pending_words[0].is_cfg) begin
          start <= 1'b0;
          if (quiet >= QUIET_CYCLES && !cfg_valid && !start) begin
            nxt = pending_words.pop_front();
            cfg_index <= nxt.idx;
            cfg_data <= nxt.cdata;
            cfg_valid <= 1'b1;
          end else begin
            cfg_valid <= 1'b0;
          end
        end else begin
          nxt = pending_words.pop_front();
          cur_word <= nxt;
          in_operation <= nxt.op;
          in_head_index <= nxt.head;
          in_element_index <= nxt.elem;
          in_value_bits <= nxt.val;
          in_key_scale <= nxt.scale;
          in_key_min <= nxt.minv;
          in_mask_bits <= nxt.mask;
          in_last_element <= nxt.last;
          start <= 1'b1;
          cfg_valid <= 1'b0;
          gap_left <= pick_gap();
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    logic [31:0] exp_v;
    if (rst_n && out_valid) begin
      if (expected_scores.size() == 0) begin
        report("score with none expected", 32'd0, out_score_bits);
      end else begin
        exp_v = expected_scores.pop_front();
        if (!(exp_v == out_score_bits || (fp_nan(exp_v) && fp_nan(out_score_bits))))
          report("score_bits", exp_v, out_score_bits);
        scores_checked++;
      end
    end
  end

  // ---------------- stimulus ----------------

  function automatic logic [31:0] rand_fp32();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom();
    return {1'($urandom), 8'($urandom_range(118, 134)), 23'($urandom)};
  endfunction

  function automatic logic [15:0] rand_fp16();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'($urandom);
    return {1'($urandom), 5'($urandom_range(9, 20)), 10'($urandom)};
  endfunction

  function automatic logic [31:0] rand_key_bits(input fmt_t f);
    logic [31:0] v;
    v = $urandom();
    if ($urandom_range(0, 99) < 12) return v;
    case (f)
      FMT_F32:  return rand_fp32();
      FMT_F16:  return {v[31:16], rand_fp16()};
      FMT_BF16: return {v[31:16], rand_fp32() >> 16};
      default:  return v;
    endcase
  endfunction

  task automatic push_word(input op_t op, input int head, input int elem,
                           input logic [31:0] val, input logic [15:0] sc,
                           input logic [15:0] mn, input logic [15:0] mk, input logic last);
    word_t w;
    w = '0;
    w.op = op;
    w.head = 6'(head);
    w.elem = 7'(elem);
    w.val = val;
    w.scale = sc;
    w.minv = mn;
    w.mask = mk;
    w.last = last;
    pending_words.push_back(w);
  endtask

  task automatic push_cfg(input reg_t idx, input logic [6:0] data);
    word_t w;
    w = '0;
    w.is_cfg = 1'b1;
    w.idx = idx;
    w.cdata = data;
    pending_words.push_back(w);
  endtask

  task automatic load_element(input int e);
    for (int h = 0; h < MAX_HEADS; h++)
      push_word(OP_QUERY, h, e, rand_fp32(), 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    if (!elem_known[e]) known_elems.push_back(e);
    elem_known[e] = 1;
  endtask

  task automatic push_key_vector(input fmt_t f, output int n);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    for (int i = 0; i < n; i++)
      push_word(OP_KEY, $urandom_range(0, 63), known_elems[$urandom_range(0, known_elems.size() - 1)],
                rand_key_bits(f), rand_fp16(), rand_fp16(), rand_fp16(), i == n - 1);
  endtask

  task automatic push_random_phase(input fmt_t f, input int target);
    int cnt, r, n, e;
    cnt = 0;
    while (cnt < target) begin
      r = $urandom_range(0, 99);
      if (r < 3 && known_elems.size() < 12) begin
        e = $urandom_range(0, EMBED_SIZE - 1);
        load_element(e);
        cnt += MAX_HEADS;
      end else if (r < 12) begin
        push_word(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 127), rand_fp32(),
                  16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
        cnt++;
      end else if (r < 20) begin
        push_word(OP_WEIGHT, $urandom_range(0, 63), $urandom_range(0, 127), rand_fp32(),
                  16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
        cnt++;
      end else if (r < 26) begin
        push_word(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 127), $urandom(),
                  16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        push_key_vector(f, n);
        cnt += n;
      end
    end
  endtask

  initial begin
    fmt_t phase_fmt [11] = '{FMT_F32, FMT_F16, FMT_BF16, FMT_Q8_0, FMT_Q4_0, FMT_Q4_1,
                             FMT_Q5_0, FMT_Q5_1, FMT_Q8_0, FMT_F32, FMT_Q4_1};
    int phase_heads [11] = '{64, 32, 64, 0, 127, 32, 1, 64, 33, 100, 63};

    for (int e = 0; e < EMBED_SIZE; e++) elem_known[e] = 0;
    for (int h = 0; h < MAX_HEADS; h++)
      push_word(OP_WEIGHT, h, 0, rand_fp32(), 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    load_element(0);
    load_element(127);

    // f16 keys at reset settings: zero, subnormal, one, inf, nan, extremes of the mask
    push_word(OP_NONE, 63, 127, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_word(OP_KEY, 0, 0, 32'hFFFF_0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    push_word(OP_KEY, 63, 127, 32'h0000_0001, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b1);
    push_word(OP_KEY, 0, 0, 32'h0000_3C00, 16'h0000, 16'h0000, 16'h7BFF, 1'b0);
    push_word(OP_KEY, 0, 127, 32'h0000_BC00, 16'h0000, 16'h0000, 16'hFBFF, 1'b1);
    push_word(OP_KEY, 0, 0, 32'h0000_7C00, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    push_word(OP_KEY, 0, 0, 32'h0000_FFFF, 16'h0000, 16'h0000, 16'h3C00, 1'b1);
    push_word(OP_KEY, 0, 127, 32'h0000_03FF, 16'h0000, 16'h0000, 16'h7C00, 1'b1);
    push_word(OP_KEY, 0, 0, 32'h0000_3C00, 16'h0000, 16'h0000, 16'h0001, 1'b1);
    push_word(OP_QUERY, 63, 127, 32'h7F7F_FFFF, 16'h0, 16'h0, 16'h0, 1'b0);
    push_word(OP_KEY, 0, 127, 32'h0000_7BFF, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    push_word(OP_QUERY, 63, 127, 32'h3F80_0000, 16'h0, 16'h0, 16'h0, 1'b0);
    push_word(OP_WEIGHT, 63, 0, 32'h0000_0000, 16'h0, 16'h0, 16'h0, 1'b0);
    push_word(OP_WEIGHT, 0, 0, 32'hBF80_0000, 16'h0, 16'h0, 16'h0, 1'b0);
    push_word(OP_KEY, 0, 127, 32'h0000_3C00, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    push_word(OP_WEIGHT, 63, 0, 32'h3F80_0000, 16'h0, 16'h0, 16'h0, 1'b0);
    push_word(OP_WEIGHT, 0, 0, 32'h3F00_0000, 16'h0, 16'h0, 16'h0, 1'b0);

    for (int p = 0; p < 11; p++) begin
      push_cfg(REG_KEY_FORMAT, {4'($urandom), 3'(phase_fmt[p])});
      push_cfg(REG_HEAD_COUNT, 7'(phase_heads[p]));
      push_random_phase(phase_fmt[p], 90);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_words.size() == 0 && !start && !cfg_valid && expected_scores.size() == 0);
    no_gaps = 0;
    repeat (300) @(posedge clk);
    $display("summary: %0d words accepted over 11 format and head count settings", words_sent);
    $display("summary: %0d scores checked, %0d mismatches", scores_checked, errors);
    if (errors == 0 && expected_scores.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // alternate stretches without gaps
  always @(posedge clk) begin
    if (cycles % 4096 == 0) no_gaps <= ($urandom_range(0, 3) == 0);
  end

endmodule

### relu_weighted_key_scorer_top.f
rtl/rwks_pkg.sv
rtl/rwks_fmul.sv
rtl/rwks_fadd.sv
rtl/rwks_cell.sv
rtl/relu_weighted_key_scorer_top.sv
rtl/rwks_checker.sv
test/testbench.sv
